### hw/rtl/assert_macros.svh
// Assertion macros shared by the permuter RTL.
// Depends on nothing; each macro takes a label, a clock, a reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/xfyp_pkg.sv
// Package for the xorshift Fisher-Yates permuter: payload and control types, constants.
// Depends on nothing.
`timescale 1ns / 1ps

package xfyp_pkg;

  localparam int SEED_W    = 64;
  localparam int DIV_CNT_W = 6;
  localparam int XS_A      = 13;
  localparam int XS_B      = 7;
  localparam int XS_C      = 17;

  localparam logic KIND_SHUFFLE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SEED_W-1:0] seed;
    logic [7:0]        index;
  } request_t;

  typedef struct packed {
    logic [7:0] entry_value;
    logic       shuffle_done;
  } result_t;

  typedef struct packed {
    logic load_seed;
    logic load_index;
    logic fill;
    logic gen;
    logic div;
    logic swap_rd;
    logic wr_i;
    logic wr_j;
    logic read_rd;
    logic read_cap;
    logic shuf_ack;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic div_last;
    logic i_one;
  } sts_t;

endpackage

### hw/rtl/xfyp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module xfyp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/xfyp_ctrl.sv
// Controller state machine of the permuter: sequences fills, generator steps, division, swaps and reads.
// Depends on xfyp_pkg.
`timescale 1ns / 1ps

module xfyp_ctrl import xfyp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [9:0] {
    ST_INIT     = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_FILL     = 10'b00_0000_0100,
    ST_GEN      = 10'b00_0000_1000,
    ST_DIV      = 10'b00_0001_0000,
    ST_SWAP_RD  = 10'b00_0010_0000,
    ST_SWAP_WI  = 10'b00_0100_0000,
    ST_SWAP_WJ  = 10'b00_1000_0000,
    ST_READ_RD  = 10'b01_0000_0000,
    ST_READ_CAP = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_SHUFFLE) begin
            cmd.load_seed = 1'b1;
            state_next    = ST_FILL;
          end else begin
            cmd.load_index = 1'b1;
            state_next     = ST_READ_RD;
          end
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) state_next = ST_GEN;
      end
      ST_GEN: begin
        cmd.gen    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) state_next = ST_SWAP_RD;
      end
      ST_SWAP_RD: begin
        cmd.swap_rd = 1'b1;
        state_next  = ST_SWAP_WI;
      end
      ST_SWAP_WI: begin
        cmd.wr_i   = 1'b1;
        state_next = ST_SWAP_WJ;
      end
      ST_SWAP_WJ: begin
        cmd.wr_j = 1'b1;
        if (sts.i_one) begin
          cmd.shuf_ack = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_GEN;
        end
      end
      ST_READ_RD: begin
        cmd.read_rd = 1'b1;
        state_next  = ST_READ_CAP;
      end
      ST_READ_CAP: begin
        cmd.read_cap = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

### hw/rtl/xfyp_datapath.sv
// Datapath of the permuter: table RAM, xorshift generator, serial divider and result register.
// Depends on xfyp_pkg and xfyp_ram.
`timescale 1ns / 1ps

module xfyp_datapath import xfyp_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  cmd_t     cmd,
  output sts_t     sts,
  output result_t  result,
  output logic     result_strobe
);

  localparam int AW = $clog2(ENTRIES);
  localparam int IW = ((AW > 8) ? AW : 8) + 1;

  logic [AW-1:0]        k;
  logic [AW-1:0]        i;
  logic [AW-1:0]        rem;
  logic [SEED_W-1:0]    x;
  logic [SEED_W-1:0]    dvd;
  logic [DIV_CNT_W-1:0] cnt;
  logic [7:0]           idx;
  logic [7:0]           hold;

  logic [SEED_W-1:0] xs1, xs2, xs3;
  logic [AW:0]       divisor;
  logic [AW:0]       trial;
  logic [IW-1:0]     idx_ext;
  logic              idx_ok;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr_a;
  logic [7:0]    rdata_a, rdata_b;

  assign xs1 = x ^ (x << XS_A);
  assign xs2 = xs1 ^ (xs1 >> XS_B);
  assign xs3 = xs2 ^ (xs2 << XS_C);

  assign divisor = {1'b0, i} + {{AW{1'b0}}, 1'b1};
  assign trial   = {rem, dvd[SEED_W-1]};

  assign idx_ext = IW'(idx);
  assign idx_ok  = (idx_ext < IW'(ENTRIES));

  assign sts.fill_last = (k == AW'(ENTRIES - 1));
  assign sts.div_last  = (cnt == {DIV_CNT_W{1'b1}});
  assign sts.i_one     = (i == AW'(1));

  assign we      = cmd.fill | cmd.wr_i | cmd.wr_j;
  assign waddr   = cmd.fill ? k : (cmd.wr_i ? i : rem);
  assign wdata   = cmd.fill ? 8'(k) : (cmd.wr_i ? rdata_b : hold);
  assign raddr_a = cmd.read_rd ? idx_ext[AW-1:0] : i;

  xfyp_ram #(
    .WIDTH (8),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (rem),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      k             <= '0;
      x             <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.read_cap | cmd.shuf_ack;
      if (cmd.load_seed) begin
        x <= request.seed;
        k <= '0;
      end else if (cmd.fill) begin
        k <= k + AW'(1);
      end
      if (cmd.gen) begin
        x <= xs3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      i <= AW'(ENTRIES - 1);
    end else if (cmd.wr_j) begin
      i <= i - AW'(1);
    end
    if (cmd.load_index) begin
      idx <= request.index;
    end
    if (cmd.gen) begin
      dvd <= xs3;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div) begin
      dvd <= dvd << 1;
      cnt <= cnt + DIV_CNT_W'(1);
      if (trial >= divisor) begin
        rem <= AW'(trial - divisor);
      end else begin
        rem <= AW'(trial);
      end
    end
    if (cmd.wr_i) begin
      hold <= rdata_a;
    end
    if (cmd.read_cap) begin
      result.entry_value  <= idx_ok ? rdata_a : 8'd0;
      result.shuffle_done <= 1'b0;
    end else if (cmd.shuf_ack) begin
      result.entry_value  <= 8'd0;
      result.shuffle_done <= 1'b1;
    end
  end

endmodule

### hw/rtl/xorshift_fisher_yates_permuter_core.sv
// Top level of the xorshift Fisher-Yates permuter: joins controller and datapath.
// Depends on xfyp_pkg, xfyp_ctrl, xfyp_datapath and assert_macros.svh.
// The core takes a request when start is high and busy is low, and later presents exactly one
// result on result for a single cycle with result_strobe high; the receiver cannot stall it,
// so it must take every result in that cycle. A read steps through ST_READ_RD and ST_READ_CAP,
// and result_strobe is registered from the capture. During a shuffle busy stays high while
// the identity reload writes one entry per cycle and, for each of the ENTRIES - 1 swaps, the
// core takes one generator step, runs the bit-serial remainder unit and uses the table RAM
// once to read both entries and once for each write through the single write port. After
// reset the core is busy while it loads the identity into the table.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xorshift_fisher_yates_permuter_core import xfyp_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output result_t  result,
  output logic     result_strobe
);

  cmd_t cmd;
  sts_t sts;

  xfyp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  xfyp_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cmd           (cmd),
    .sts           (sts),
    .result        (result),
    .result_strobe (result_strobe)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_single_strobe, clk, rst, result_strobe, !result_strobe)
  `ASSERT_SAME(a_ack_zero, clk, rst, result_strobe && result.shuffle_done, result.entry_value == '0)
  `ASSERT_NEXT(a_strobe_idle, clk, rst, cmd.read_cap || cmd.shuf_ack, !busy && result_strobe)

endmodule
